### hw/rtl/cas_pkg.sv
// Shared types and constants of the cut-and-splice crossover block.
package cas_pkg;

   localparam int GENE_PORT_W = 32;
   localparam int KIND_W      = 2;
   localparam int MIN_LEN_W   = 7;
   localparam int RAND_W      = 32;

   localparam logic [MIN_LEN_W-1:0] MIN_LEN_RESET = 7'd1;

   localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RUN    = 2'd2;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_COUNT    = 7'b0000010,
      ST_DIV_PICK = 7'b0000100,
      ST_SELECT   = 7'b0001000,
      ST_DIV_FA   = 7'b0010000,
      ST_DIV_FB   = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } state_type;

   // Output segments in emission order.
   typedef enum logic [1:0] {
      SEG_A_HEAD = 2'd0,
      SEG_B_TAIL = 2'd1,
      SEG_B_HEAD = 2'd2,
      SEG_A_TAIL = 2'd3
   } seg_type;

endpackage

### hw/rtl/cas_div.sv
// Bit-serial remainder unit: one dividend bit per cycle.
module cas_div
   import cas_pkg::*;
#(
   parameter int DVW = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [RAND_W-1:0]   dividend,
   input  logic [DVW-1:0]      divisor,
   output logic                done,
   output logic [DVW-1:0]      remainder
);

   localparam int CNT_W = $clog2(RAND_W);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RAND_W-1:0] dvd_ff, dvd_in;
   logic [DVW-1:0]    dvs_ff, dvs_in;
   logic [DVW-1:0]    rem_ff, rem_in;
   logic [DVW:0]      trial;

   assign trial = {rem_ff, dvd_ff[RAND_W-1]};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 1'b1;
         dvd_in = dvd_ff << 1;
         // restoring step: subtract when the partial remainder reaches the divisor
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVW'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = DVW'(trial);
         end
         if (cnt_ff == CNT_W'(RAND_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

### hw/rtl/cut_and_splice_crossover.sv
// Cut-and-splice crossover: loads one gene request per cycle into parent A or B while
// idle. A run request counts valid cut pairs one c1 row per cycle, reduces random_a by
// the count in a bit-serial remainder unit, walks the rows again to locate the chosen
// pair; with no valid pair it runs two reductions instead. Genes then leave the two
// parent memories one read at a time, each waiting until the previous word is in the
// output register and the output is free; a segment boundary takes a step with no read.
// The final result carries last and both parents are emptied. New requests are taken
// once the last read reaches the output. If either parent is empty, counting is skipped.
module cut_and_splice_crossover
   import cas_pkg::*;
#(
   parameter int MAX_LEN    = 32,
   parameter int GENE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [GENE_PORT_W-1:0] req_gene,
   input  logic [RAND_W-1:0]      req_random_a,
   input  logic [RAND_W-1:0]      req_random_b,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_child,
   output logic [GENE_PORT_W-1:0] rsp_gene_res,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  logic [MIN_LEN_W-1:0]   csr_wdata
);

   localparam int SW = (GENE_WIDTH < GENE_PORT_W) ? GENE_WIDTH : GENE_PORT_W;
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2((MAX_LEN + 1) * (MAX_LEN + 1) + 1);
   localparam int DW = ((LW > MIN_LEN_W) ? LW : MIN_LEN_W) + 2;

   logic [SW-1:0] mem_a [MAX_LEN];
   logic [SW-1:0] mem_b [MAX_LEN];

   state_type            state_ff, state_in;
   logic [MIN_LEN_W-1:0] min_len_ff, min_len_in;
   logic [LW-1:0]        la_ff, la_in, lb_ff, lb_in;
   logic [RAND_W-1:0]    ra_ff, ra_in, rb_ff, rb_in;
   logic [LW-1:0]        c1_ff, c1_in, c2_ff, c2_in;
   logic [LW-1:0]        row_ff, row_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        pick_ff, pick_in;
   logic                 go_ff, go_in;
   seg_type              seg_ff, seg_in;
   logic [LW-1:0]        idx_ff, idx_in;
   logic [LW:0]          left_ff, left_in;
   logic                 pend_ff, pend_in;
   logic                 pend_b_ff, pend_b_in;
   logic                 pend_child_ff, pend_child_in;
   logic                 pend_last_ff, pend_last_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_child_ff, rsp_child_in;
   logic [SW-1:0]        rsp_gene_ff, rsp_gene_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [SW-1:0]        rd_a_ff, rd_b_ff;

   logic                 req_take;
   logic                 wr_a, wr_b;
   logic [SW-1:0]        gene_w;
   logic                 can_issue;
   logic [LW-1:0]        seg_end;

   logic signed [DW-1:0] c1_s, la_s, lb_s, m_s;
   logic signed [DW-1:0] hi_s, lo_s, hi_c, lo_c;
   logic [CW-1:0]        row_cnt;
   logic [CW-1:0]        cnt_total;

   logic                 div_start;
   logic [RAND_W-1:0]    div_dividend;
   logic [CW-1:0]        div_divisor;
   logic                 div_done;
   logic [CW-1:0]        div_rem;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign gene_w    = SW'(req_gene);
   assign wr_a = req_take && (req_kind == KIND_LOAD_A) && (la_ff < LW'(MAX_LEN));
   assign wr_b = req_take && (req_kind == KIND_LOAD_B) && (lb_ff < LW'(MAX_LEN));

   // Valid c2 for one c1 row: c1+lb-m >= c2 >= c1+m-la, clipped to 0..lb.
   assign c1_s = $signed(DW'(row_ff));
   assign la_s = $signed(DW'(la_ff));
   assign lb_s = $signed(DW'(lb_ff));
   assign m_s  = $signed(DW'(min_len_ff));
   assign hi_s = c1_s + lb_s - m_s;
   assign lo_s = c1_s + m_s - la_s;
   assign hi_c = (hi_s > lb_s) ? lb_s : hi_s;
   assign lo_c = (lo_s < 0) ? '0 : lo_s;
   assign row_cnt   = (hi_c >= lo_c) ? CW'(hi_c - lo_c + 1) : '0;
   assign cnt_total = cnt_ff + row_cnt;

   assign div_start    = go_ff;
   assign div_dividend = (state_ff == ST_DIV_FB) ? rb_ff : ra_ff;

   always_comb begin
      case (state_ff)
         ST_DIV_FA: div_divisor = CW'(la_ff) + 1'b1;
         ST_DIV_FB: div_divisor = CW'(lb_ff) + 1'b1;
         default:   div_divisor = cnt_ff;
      endcase
   end

   always_comb begin
      case (seg_ff)
         SEG_A_HEAD: seg_end = c1_ff;
         SEG_B_TAIL: seg_end = lb_ff;
         SEG_B_HEAD: seg_end = c2_ff;
         default:    seg_end = la_ff;
      endcase
   end

   assign can_issue = !pend_ff && (!rsp_valid_ff || rsp_ready);

   cas_div #(
      .DVW (CW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in      = state_ff;
      min_len_in    = csr_we ? csr_wdata : min_len_ff;
      la_in         = wr_a ? la_ff + 1'b1 : la_ff;
      lb_in         = wr_b ? lb_ff + 1'b1 : lb_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      c1_in         = c1_ff;
      c2_in         = c2_ff;
      row_in        = row_ff;
      cnt_in        = cnt_ff;
      pick_in       = pick_ff;
      go_in         = 1'b0;
      seg_in        = seg_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      pend_in       = 1'b0;
      pend_b_in     = pend_b_ff;
      pend_child_in = pend_child_ff;
      pend_last_in  = pend_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_kind == KIND_RUN)) begin
               ra_in = req_random_a;
               rb_in = req_random_b;
               if ((la_ff == '0) || (lb_ff == '0)) begin
                  c1_in    = la_ff;
                  c2_in    = lb_ff;
                  seg_in   = SEG_A_HEAD;
                  idx_in   = '0;
                  left_in  = (LW + 1)'(la_ff) + (LW + 1)'(lb_ff);
                  state_in = ST_EMIT;
               end else begin
                  row_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_COUNT;
               end
            end
         end
         ST_COUNT: begin
            cnt_in = cnt_total;
            row_in = row_ff + 1'b1;
            if (row_ff == la_ff) begin
               go_in    = 1'b1;
               state_in = (cnt_total != '0) ? ST_DIV_PICK : ST_DIV_FA;
            end
         end
         ST_DIV_PICK: begin
            if (div_done) begin
               pick_in  = div_rem;
               row_in   = '0;
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (pick_ff < row_cnt) begin
               c1_in    = row_ff;
               c2_in    = LW'(lo_c) + LW'(pick_ff);
               seg_in   = SEG_A_HEAD;
               idx_in   = '0;
               left_in  = (LW + 1)'(la_ff) + (LW + 1)'(lb_ff);
               state_in = ST_EMIT;
            end else begin
               pick_in = pick_ff - row_cnt;
               row_in  = row_ff + 1'b1;
            end
         end
         ST_DIV_FA: begin
            if (div_done) begin
               c1_in    = LW'(div_rem);
               go_in    = 1'b1;
               state_in = ST_DIV_FB;
            end
         end
         ST_DIV_FB: begin
            if (div_done) begin
               c2_in    = LW'(div_rem);
               seg_in   = SEG_A_HEAD;
               idx_in   = '0;
               left_in  = (LW + 1)'(la_ff) + (LW + 1)'(lb_ff);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (left_ff == '0) begin
               // all reads issued: empty both parents
               if (!pend_ff) begin
                  la_in    = '0;
                  lb_in    = '0;
                  state_in = ST_IDLE;
               end
            end else if (idx_ff == seg_end) begin
               // advance to the next segment
               case (seg_ff)
                  SEG_A_HEAD: begin
                     seg_in = SEG_B_TAIL;
                     idx_in = c2_ff;
                  end
                  SEG_B_TAIL: begin
                     seg_in = SEG_B_HEAD;
                     idx_in = '0;
                  end
                  default: begin
                     seg_in = SEG_A_TAIL;
                     idx_in = c1_ff;
                  end
               endcase
            end else if (can_issue) begin
               pend_in       = 1'b1;
               pend_b_in     = (seg_ff == SEG_B_TAIL) || (seg_ff == SEG_B_HEAD);
               pend_child_in = (seg_ff == SEG_B_HEAD) || (seg_ff == SEG_A_TAIL);
               pend_last_in  = (left_ff == (LW + 1)'(1));
               idx_in        = idx_ff + 1'b1;
               left_in       = left_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load the memory word in the cycle after its read, hold while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_child_in = rsp_child_ff;
      rsp_gene_in  = rsp_gene_ff;
      rsp_last_in  = rsp_last_ff;
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_child_in = pend_child_ff;
         rsp_gene_in  = pend_b_ff ? rd_b_ff : rd_a_ff;
         rsp_last_in  = pend_last_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_len_ff   <= MIN_LEN_RESET;
         la_ff        <= '0;
         lb_ff        <= '0;
         go_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_len_ff   <= min_len_in;
         la_ff        <= la_in;
         lb_ff        <= lb_in;
         go_ff        <= go_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      c1_ff         <= c1_in;
      c2_ff         <= c2_in;
      row_ff        <= row_in;
      cnt_ff        <= cnt_in;
      pick_ff       <= pick_in;
      seg_ff        <= seg_in;
      idx_ff        <= idx_in;
      left_ff       <= left_in;
      pend_b_ff     <= pend_b_in;
      pend_child_ff <= pend_child_in;
      pend_last_ff  <= pend_last_in;
      rsp_child_ff  <= rsp_child_in;
      rsp_gene_ff   <= rsp_gene_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[la_ff[AW-1:0]] <= gene_w;
      end
      rd_a_ff <= mem_a[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[lb_ff[AW-1:0]] <= gene_w;
      end
      rd_b_ff <= mem_b[idx_ff[AW-1:0]];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_child    = rsp_child_ff;
   assign rsp_gene_res = GENE_PORT_W'(rsp_gene_ff);
   assign rsp_last     = rsp_last_ff;

endmodule
